// File: rtl/core/mlqs_pkg.sv
// Shared types and constants for the multilevel queue batch scheduler.
// No dependencies.
`timescale 1ns / 1ps

package mlqs_pkg;

    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int JOB_ID_W = 6;
    localparam int ENTRY_W  = BURST_W + PRIO_W;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;

    localparam logic LEVEL_RR   = 1'b0;
    localparam logic LEVEL_PRIO = 1'b1;

    typedef struct packed {
        logic [JOB_ID_W-1:0] job_id;
        logic                level;
        logic [BURST_W-1:0]  run_units;
        logic [BURST_W-1:0]  time_left;
        logic                finished;
        logic                last_result;
    } result_t;

endpackage

// File: rtl/core/mlqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mlqs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mlqs_ctrl.sv
// Sequencer: loads jobs into the job store, then walks it for the round-robin
// pass and once per priority selection. Depends on mlqs_pkg.
`timescale 1ns / 1ps

module mlqs_ctrl #(
    parameter int MAX_JOBS = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic                                        last_job,
    input  logic [mlqs_pkg::BURST_W-1:0]                burst_time,
    input  logic [mlqs_pkg::PRIO_W-1:0]                 priority_value,
    input  logic [mlqs_pkg::BURST_W-1:0]                quantum,
    input  logic [mlqs_pkg::ENTRY_W-1:0]                ram_rdata,
    output logic                                        busy,
    output logic                                        ram_we,
    output logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] ram_waddr,
    output logic [mlqs_pkg::ENTRY_W-1:0]                ram_wdata,
    output logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] ram_raddr,
    output logic                                        result_valid,
    output mlqs_pkg::result_t                           result
);

    import mlqs_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RR,
        ST_SCAN
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      addr_reg, addr_next;
    logic                  issue_reg, issue_next;
    logic                  dv_reg, dv_next;
    logic [IDX_W-1:0]      dtag_reg, dtag_next;
    logic [MAX_JOBS-1:0]   mask_reg, mask_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]     best_prio_reg, best_prio_next;
    logic [BURST_W-1:0]    best_burst_reg, best_burst_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic                  full;
    logic [IDX_W-1:0]      last_idx;
    logic [BURST_W-1:0]    rd_burst;
    logic [PRIO_W-1:0]     rd_prio;
    logic                  demote;
    logic                  take;
    logic [IDX_W-1:0]      sel_idx;
    logic [BURST_W-1:0]    sel_burst;

    assign full      = (cnt_reg >= CNT_W'(MAX_JOBS));
    assign last_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign rd_burst  = ram_rdata[BURST_W-1:0];
    assign rd_prio   = ram_rdata[ENTRY_W-1:BURST_W];

    assign ram_we    = (state_reg == ST_IDLE) && start && !full;
    assign ram_waddr = IDX_W'(cnt_reg);
    assign ram_wdata = {priority_value, burst_time};
    assign ram_raddr = addr_reg;

    assign demote    = (rd_burst > quantum);
    // Strict compare on an ascending walk keeps the earliest demoted job on ties
    assign take      = dv_reg && mask_reg[dtag_reg]
                       && (!found_reg || (rd_prio < best_prio_reg));
    assign sel_idx   = take ? dtag_reg : best_idx_reg;
    assign sel_burst = take ? rd_burst : best_burst_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        dv_next         = issue_reg;
        dtag_next       = addr_reg;
        mask_next       = mask_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_burst_next = best_burst_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;

        // Advance the read address while a walk is under way
        if (issue_reg)
        begin
            addr_next = addr_reg + IDX_W'(1);
            if (addr_reg == last_idx)
            begin
                issue_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!full)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (last_job)
                    begin
                        state_next = ST_RR;
                        addr_next  = '0;
                        issue_next = 1'b1;
                    end
                end
            end

            ST_RR:
            begin
                if (dv_reg)
                begin
                    res_valid_next       = 1'b1;
                    res_next.job_id      = JOB_ID_W'(dtag_reg) + JOB_ID_W'(1);
                    res_next.level       = LEVEL_RR;
                    res_next.last_result = 1'b0;
                    if (demote)
                    begin
                        res_next.run_units  = quantum;
                        res_next.time_left  = rd_burst - quantum;
                        res_next.finished   = 1'b0;
                        mask_next[dtag_reg] = 1'b1;
                    end
                    else
                    begin
                        res_next.run_units = rd_burst;
                        res_next.time_left = '0;
                        res_next.finished  = 1'b1;
                    end
                    if (dtag_reg == last_idx)
                    begin
                        if (|mask_next)
                        begin
                            state_next = ST_SCAN;
                            addr_next  = '0;
                            issue_next = 1'b1;
                            found_next = 1'b0;
                        end
                        else
                        begin
                            state_next           = ST_IDLE;
                            cnt_next             = '0;
                            res_next.last_result = 1'b1;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (take)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = dtag_reg;
                    best_prio_next  = rd_prio;
                    best_burst_next = rd_burst;
                end
                if (dv_reg && (dtag_reg == last_idx))
                begin
                    res_valid_next       = 1'b1;
                    res_next.job_id      = JOB_ID_W'(sel_idx) + JOB_ID_W'(1);
                    res_next.level       = LEVEL_PRIO;
                    res_next.run_units   = sel_burst - quantum;
                    res_next.time_left   = '0;
                    res_next.finished    = 1'b1;
                    res_next.last_result = 1'b0;
                    mask_next[sel_idx]   = 1'b0;
                    if (|mask_next)
                    begin
                        addr_next  = '0;
                        issue_next = 1'b1;
                        found_next = 1'b0;
                    end
                    else
                    begin
                        state_next           = ST_IDLE;
                        cnt_next             = '0;
                        res_next.last_result = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            mask_reg      <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            issue_reg     <= issue_next;
            dv_reg        <= dv_next;
            mask_reg      <= mask_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dtag_reg       <= dtag_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_burst_reg <= best_burst_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: rtl/core/multilevel_queue_batch_scheduler_core.sv
// Top level of the multilevel queue batch scheduler: quantum register, job
// store and sequencer. Depends on mlqs_pkg, mlqs_ram and mlqs_ctrl.
`timescale 1ns / 1ps

// Usage
//   Request channel: a job is taken at a clock edge with start high and busy
//   low; burst_time and priority_value are stored and the job id is its load
//   order from 1. Jobs load at one per cycle. Jobs beyond MAX_JOBS are
//   dropped; a request with last_job high still starts the schedule.
//   Result channel: result_valid marks each slot for exactly one cycle; the
//   receiver cannot stall it. last_result flags the final slot.
//   Timing: the round-robin pass walks the loaded jobs in the store once;
//   its first slot passes the store's read register and the result register
//   after the last request, then one slot per cycle. Each priority slot
//   needs a full walk of the single-read-port store to find the lowest
//   priority value. busy stays high from the last request until the final
//   slot is issued; it is low in that cycle, when the next batch may load.
//   Configuration: cfg_we writes cfg_wdata into the time quantum; write it
//   only while busy is low.
//   Reset: no jobs held, quantum 4; the store contents are not cleared and
//   need no clearing pass.

module multilevel_queue_batch_scheduler_core #(
    parameter int MAX_JOBS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mlqs_pkg::BURST_W-1:0]       burst_time,
    input  logic [mlqs_pkg::PRIO_W-1:0]        priority_value,
    input  logic                               last_job,
    input  logic                               cfg_we,
    input  logic [mlqs_pkg::BURST_W-1:0]       cfg_wdata,
    output logic                               result_valid,
    output logic [mlqs_pkg::JOB_ID_W-1:0]      job_id,
    output logic                               level,
    output logic [mlqs_pkg::BURST_W-1:0]       run_units,
    output logic [mlqs_pkg::BURST_W-1:0]       time_left,
    output logic                               finished,
    output logic                               last_result
);

    import mlqs_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    logic [BURST_W-1:0] time_quantum_reg;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    result_t            result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_we)
        begin
            time_quantum_reg <= cfg_wdata;
        end
    end

    mlqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_JOBS)
    ) u_job_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mlqs_ctrl #(
        .MAX_JOBS (MAX_JOBS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .last_job       (last_job),
        .burst_time     (burst_time),
        .priority_value (priority_value),
        .quantum        (time_quantum_reg),
        .ram_rdata      (ram_rdata),
        .busy           (busy),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .result_valid   (result_valid),
        .result         (result)
    );

    assign job_id      = result.job_id;
    assign level       = result.level;
    assign run_units   = result.run_units;
    assign time_left   = result.time_left;
    assign finished    = result.finished;
    assign last_result = result.last_result;

    // Final slot closes the schedule; any earlier slot leaves it running
    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |-> !busy)
        else $error("final slot issued while schedule still running");

    a_slot_inside_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |-> busy)
        else $error("slot issued with no schedule running");

    a_finish_no_time: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && finished) |-> (time_left == '0))
        else $error("completed job reports time left");

    a_demote_quantum: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !finished) |->
            ((level == LEVEL_RR) && (run_units == time_quantum_reg)))
        else $error("demoted job did not run exactly one quantum");

endmodule

// File: dv/multilevel_queue_batch_scheduler_core_test.sv
// Self-checking testbench for multilevel_queue_batch_scheduler_core: a scoreboard
// class predicts every schedule slot, plain tasks load jobs and set the quantum.
// Depends on mlqs_pkg and the scheduler RTL.
`timescale 1ns / 1ps

class schedule_scoreboard;
    localparam int JOBS = 32;

    logic [mlqs_pkg::BURST_W-1:0] quantum;
    logic [mlqs_pkg::BURST_W-1:0] burst_mem [JOBS];
    logic [mlqs_pkg::PRIO_W-1:0]  prio_mem [JOBS];
    int unsigned                  jobs_held;
    mlqs_pkg::result_t            slots_due [$];
    int unsigned                  mismatches;

    function new();
        quantum    = mlqs_pkg::QUANTUM_RESET;
        jobs_held  = 0;
        mismatches = 0;
    endfunction

    function void note_fail(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function string show(mlqs_pkg::result_t r);
        return $sformatf("job %0d level %0d run %0d left %0d finished %0d last %0d",
                         r.job_id, r.level, r.run_units, r.time_left, r.finished,
                         r.last_result);
    endfunction

    function void add_slot(logic [mlqs_pkg::JOB_ID_W-1:0] id, logic lvl,
                           logic [mlqs_pkg::BURST_W-1:0] run,
                           logic [mlqs_pkg::BURST_W-1:0] left, logic fin);
        mlqs_pkg::result_t slot;
        slot = '{id, lvl, run, left, fin, 1'b0};
        slots_due.push_back(slot);
    endfunction

    // Store one request and, on the last job of a batch, plan every slot.
    function void load_job(logic [mlqs_pkg::BURST_W-1:0] burst,
                           logic [mlqs_pkg::PRIO_W-1:0] prio, logic last);
        logic [JOBS-1:0]   demoted;
        int                best;
        mlqs_pkg::result_t tail;
        if (jobs_held < JOBS)
        begin
            burst_mem[jobs_held] = burst;
            prio_mem[jobs_held]  = prio;
            jobs_held++;
        end
        if (!last)
            return;
        demoted = '0;
        for (int i = 0; i < jobs_held; i++)
        begin
            if (burst_mem[i] > quantum)
            begin
                add_slot(6'(i + 1), mlqs_pkg::LEVEL_RR, quantum, burst_mem[i] - quantum, 1'b0);
                demoted[i] = 1'b1;
            end
            else
                add_slot(6'(i + 1), mlqs_pkg::LEVEL_RR, burst_mem[i], '0, 1'b1);
        end
        // lowest priority value wins, ties to the earliest job
        while (demoted != '0)
        begin
            best = -1;
            for (int i = 0; i < jobs_held; i++)
                if (demoted[i] && (best < 0 || prio_mem[i] < prio_mem[best]))
                    best = i;
            demoted[best] = 1'b0;
            add_slot(6'(best + 1), mlqs_pkg::LEVEL_PRIO, burst_mem[best] - quantum, '0, 1'b1);
        end
        if (slots_due.size() != 0)
        begin
            tail = slots_due.pop_back();
            tail.last_result = 1'b1;
            slots_due.push_back(tail);
        end
        jobs_held = 0;
    endfunction

    function void check_slot(mlqs_pkg::result_t got);
        mlqs_pkg::result_t want;
        if (slots_due.size() == 0)
        begin
            note_fail({"unexpected slot: ", show(got)});
            return;
        end
        want = slots_due.pop_front();
        if (got !== want)
            note_fail({"slot mismatch: expected ", show(want), ", got ", show(got)});
    endfunction
endclass

module multilevel_queue_batch_scheduler_core_test;
    import mlqs_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [BURST_W-1:0]  burst_time;
    logic [PRIO_W-1:0]   priority_value;
    logic                last_job;
    logic                cfg_we;
    logic [BURST_W-1:0]  cfg_wdata;
    logic                result_valid;
    logic [JOB_ID_W-1:0] job_id;
    logic                level;
    logic [BURST_W-1:0]  run_units;
    logic [BURST_W-1:0]  time_left;
    logic                finished;
    logic                last_result;

    schedule_scoreboard  sb = new();
    bit                  steady;
    int unsigned         items_sent;

    multilevel_queue_batch_scheduler_core #(
        .MAX_JOBS(32)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .burst_time     (burst_time),
        .priority_value (priority_value),
        .last_job       (last_job),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .result_valid   (result_valid),
        .job_id         (job_id),
        .level          (level),
        .run_units      (run_units),
        .time_left      (time_left),
        .finished       (finished),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("multilevel_queue_batch_scheduler_core: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
            sb.check_slot({job_id, level, run_units, time_left, finished, last_result});
    end

    task automatic send_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                            input logic last);
        int gap;
        start          <= 1'b1;
        burst_time     <= burst;
        priority_value <= prio;
        last_job       <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.load_job(burst, prio, last);
        items_sent++;
        gap = steady ? 0 : $urandom_range(0, 4);
        // drop start after the last job so the next batch waits for the schedule
        if (last && gap == 0)
            gap = 1;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        while (sb.slots_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_quantum(input logic [BURST_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.quantum = value;
    endtask

    function automatic logic [BURST_W-1:0] pick_burst(logic [BURST_W-1:0] q);
        int unsigned top;
        top = 2 * q + 3;
        if (top > 65535)
            top = 65535;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [BURST_W-1:0] pick_quantum();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 2));
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    initial
    begin
        int batch_len;
        int batch_no;
        int prio_top;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        burst_time     <= '0;
        priority_value <= '0;
        last_job       <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        steady         = 1'b0;
        items_sent     = 0;
        batch_no       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset quantum: zero burst alone, then equal-to-quantum, ties and extremes
        send_job(16'd0, 8'd0, 1'b1);
        send_job(16'hFFFF, 8'hFF, 1'b0);
        send_job(16'd4, 8'd0, 1'b0);
        send_job(16'd5, 8'd7, 1'b0);
        send_job(16'd3, 8'd7, 1'b0);
        send_job(16'd10, 8'd7, 1'b0);
        send_job(16'hFFFF, 8'd0, 1'b1);

        // zero quantum demotes every nonzero burst untouched
        write_quantum(16'd0);
        send_job(16'd0, 8'h80, 1'b0);
        send_job(16'd1, 8'd1, 1'b0);
        send_job(16'hFFFF, 8'd1, 1'b1);

        write_quantum(16'hFFFF);
        send_job(16'hFFFF, 8'hFF, 1'b0);
        send_job(16'hFFFE, 8'd0, 1'b1);

        write_quantum(16'd1);
        send_job(16'd1, 8'h55, 1'b0);
        send_job(16'd2, 8'hFF, 1'b0);
        send_job(16'd2, 8'hFF, 1'b1);

        while (items_sent < 470)
        begin
            if (batch_no % 6 == 5)
                write_quantum(pick_quantum());
            // now and then overrun capacity so the extra jobs are dropped
            batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                    : $urandom_range(1, 12);
            steady    = ($urandom_range(0, 3) == 0);
            prio_top  = $urandom_range(0, 1) ? 3 : 255;
            for (int j = 0; j < batch_len; j++)
                send_job(pick_burst(sb.quantum), 8'($urandom_range(0, prio_top)),
                         j == batch_len - 1);
            batch_no++;
        end

        settle();
        repeat (32) @(posedge clk);
        if (sb.slots_due.size() != 0)
            sb.note_fail($sformatf("%0d slots never arrived", sb.slots_due.size()));
        if (sb.mismatches == 0)
            $display("multilevel_queue_batch_scheduler_core: match");
        else
            $display("multilevel_queue_batch_scheduler_core: mismatch");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/mlqs_pkg.sv
rtl/core/mlqs_ram.sv
rtl/core/mlqs_ctrl.sv
rtl/core/multilevel_queue_batch_scheduler_core.sv
dv/multilevel_queue_batch_scheduler_core_test.sv
